// ===== rtl/core/stri_pkg.sv =====
package stri_pkg;

  // Table geometry and field widths.
  localparam int DEPTH         = 16;
  localparam int KEY_W         = 32;
  localparam int PAY_W         = 32;
  localparam int RANK_W        = 4;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 5;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int IDX_W         = $clog2(DEPTH);
  localparam int RCMP_W        = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  // Stream data widths, rounded up to whole bytes.
  localparam int IN_BITS      = KEY_W + PAY_W + RANK_W;
  localparam int OUT_BITS     = KEY_W + PAY_W + ENTRY_COUNT_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes carried in the input tuser bit.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_BAD_RANK = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // One request to the table.
  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
    logic [RANK_W-1:0]       rank;
  } op_t;

  // Outcome of one request, with the count after it.
  typedef struct packed {
    status_t                 status;
    logic signed [KEY_W-1:0] removed_key;
    logic [PAY_W-1:0]        removed_payload;
    logic [CNT_W-1:0]        count;
  } res_t;

endpackage

// ===== rtl/core/sorted_table_insert_rank_delete_core.sv =====
// Sorted record table with insert and remove by rank.
//
// Input beats carry one request: in_tuser is the mode (0 insert, 1 remove),
// in_tdata holds the key, payload and rank. Every request yields exactly one
// output beat with a status in out_tuser and the removed record plus the
// entry count after the request in out_tdata.
//
// A request is captured in an input register, evaluated against the table by
// one parallel compare and shift over all entries, and its result is written
// into the output register in the same edge that updates the table. out_tvalid
// rises once the request moves on into the output register, which a result
// held on out_tready can stall; throughput is one request per cycle while
// out_tready is high, set by the combinational compare and shift of the table.
//
// The input side keeps accepting while a result waits on out_tready, until
// both the input and output registers are full; then in_tready drops and the
// held result stays stable until taken.
//
// Reset empties the table (count to zero) and clears the valid flags of both
// registers; in_tready is high as soon as reset is released.
module sorted_table_insert_rank_delete_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // mode
  input  logic                                in_tuser,
  // record_key[31:0], record_payload[63:32], rank[67:64], zero fill
  input  logic [stri_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status[1:0]
  output logic [stri_pkg::STATUS_W-1:0]       out_tuser,
  // removed_key[31:0], removed_payload[63:32], entry_count[68:64], zero fill
  output logic [stri_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import stri_pkg::*;

  logic  s1_valid_r;
  logic  s1_valid_nxt;
  op_t   s1_op_r;
  logic  out_valid_r;
  logic  out_valid_nxt;
  res_t  out_res_r;
  res_t  tbl_res;
  logic  s1_adv;
  logic  in_acc;
  logic [31:0] count_wide;

  // Handshake control of the two register stages.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register unpacks the beat.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r.mode    <= in_tuser;
      s1_op_r.key     <= in_tdata[KEY_W-1:0];
      s1_op_r.payload <= in_tdata[KEY_W+PAY_W-1:KEY_W];
      s1_op_r.rank    <= in_tdata[KEY_W+PAY_W+RANK_W-1:KEY_W+PAY_W];
    end
  end

  stri_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .op_en (s1_adv),
    .op    (s1_op_r),
    .res   (tbl_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= tbl_res;
    end
  end

  assign count_wide = 32'(out_res_r.count);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = OUT_TDATA_W'({count_wide[ENTRY_COUNT_W-1:0],
                                    out_res_r.removed_payload,
                                    out_res_r.removed_key});

  // The count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.count <= CNT_W'(DEPTH)))
    else $error("entry count above depth");

  // A failed request reports no removed record.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != ST_DONE) |->
      (out_res_r.removed_key == '0 && out_res_r.removed_payload == '0))
    else $error("removed record on failed request");

  // Back-to-back results move the count by one at most.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && $past(s1_adv) && $past(out_valid_r) && $past(out_tready) && rst_n
     && $past(rst_n)) |->
      (out_res_r.count == $past(out_res_r.count) + CNT_W'(1) ||
       out_res_r.count == $past(out_res_r.count) - CNT_W'(1) ||
       out_res_r.count == $past(out_res_r.count)))
    else $error("entry count jumped");

  // An empty output register never blocks the input side.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with output register empty");

endmodule

// ===== rtl/core/stri_table.sv =====
module stri_table (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           op_en,
  input  stri_pkg::op_t  op,
  output stri_pkg::res_t res
);
  import stri_pkg::*;

  logic signed [KEY_W-1:0] keys_r     [DEPTH];
  logic signed [KEY_W-1:0] keys_nxt   [DEPTH];
  logic [PAY_W-1:0]        pays_r     [DEPTH];
  logic [PAY_W-1:0]        pays_nxt   [DEPTH];
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;

  logic [DEPTH-1:0]  lt;
  logic [DEPTH-1:0]  at_pos;
  logic              ins_ok;
  logic              rem_ok;
  logic [RCMP_W-1:0] rank_cmp;
  logic [IDX_W-1:0]  rank_idx;
  logic              do_write;

  // Every stored key below the new key sits ahead of it; the table is sorted,
  // so these flags form a prefix and the first clear flag is the slot.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (CNT_W'(i) < count_r) && (keys_r[i] < op.key);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        at_pos[i] = !lt[0];
      end else begin
        at_pos[i] = !lt[i] && lt[i-1];
      end
    end
  end

  assign ins_ok   = (count_r != CNT_W'(DEPTH));
  assign rank_cmp = RCMP_W'(op.rank);
  assign rem_ok   = (rank_cmp < RCMP_W'(count_r));
  assign rank_idx = rank_cmp[IDX_W-1:0];

  // Shifted copies of the table for both operations.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (op.mode == MODE_INSERT) begin
        if (lt[i]) begin
          keys_nxt[i] = keys_r[i];
          pays_nxt[i] = pays_r[i];
        end else if (at_pos[i] || i == 0) begin
          keys_nxt[i] = op.key;
          pays_nxt[i] = op.payload;
        end else begin
          keys_nxt[i] = keys_r[IDX_W'(i - 1)];
          pays_nxt[i] = pays_r[IDX_W'(i - 1)];
        end
      end else begin
        if (IDX_W'(i) < rank_idx || i == DEPTH - 1) begin
          keys_nxt[i] = keys_r[i];
          pays_nxt[i] = pays_r[i];
        end else begin
          keys_nxt[i] = keys_r[IDX_W'(i + 1)];
          pays_nxt[i] = pays_r[IDX_W'(i + 1)];
        end
      end
    end
  end

  // Status, removed record and new count.
  always_comb begin
    res.removed_key     = '0;
    res.removed_payload = '0;
    count_nxt           = count_r;
    do_write            = 1'b0;
    if (op.mode == MODE_INSERT) begin
      if (ins_ok) begin
        res.status = ST_DONE;
        count_nxt  = count_r + CNT_W'(1);
        do_write   = 1'b1;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      if (rem_ok) begin
        res.status          = ST_DONE;
        res.removed_key     = keys_r[rank_idx];
        res.removed_payload = pays_r[rank_idx];
        count_nxt           = count_r - CNT_W'(1);
        do_write            = 1'b1;
      end else begin
        res.status = ST_BAD_RANK;
      end
    end
    res.count = count_nxt;
  end

  // Table storage; entries at or above the count are never read.
  always_ff @(posedge clk) begin
    if (op_en && do_write) begin
      keys_r <= keys_nxt;
      pays_r <= pays_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (op_en) begin
      count_r <= count_nxt;
    end
  end

endmodule
